// ----- rtl/tmt_pkg.sv -----
// Shared widths and codes for the typed mutex table.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package tmt_pkg;

    // field widths of a request beat
    localparam int ACTION_W = 2;
    localparam int INDEX_W  = 4;
    localparam int CORE_W   = 4;
    localparam int TYPE_W   = 3;

    // field widths of a response beat
    localparam int STATUS_W    = 3;
    localparam int DEPTH_OUT_W = 16;

    // widest entry depth counter
    localparam int DEPTH_WIDE_W = 32;

    // reachable entries and cores given the index and core fields
    localparam int INDEX_REACH = 1 << INDEX_W;
    localparam int CORE_REACH_MAX = 1 << CORE_W;

    // request actions
    localparam logic [ACTION_W-1:0] ACT_INIT    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOCK    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_TRYLOCK = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_UNLOCK  = 2'd3;

    // mutex types
    localparam logic [TYPE_W-1:0] TYPE_NORMAL     = 3'd0;
    localparam logic [TYPE_W-1:0] TYPE_ERRORCHECK = 3'd1;
    localparam logic [TYPE_W-1:0] TYPE_RECURSIVE  = 3'd2;
    localparam logic [TYPE_W-1:0] TYPE_DEFAULT    = 3'd3;
    localparam logic [TYPE_W-1:0] TYPE_NONE       = 3'd7;

    // response status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DEADLOCK  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_AGAIN     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BUSY      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOT_OWNER = 3'd5;
    localparam logic [STATUS_W-1:0] ST_WAIT      = 3'd6;

endpackage

// ----- rtl/tmt_req_if.sv -----
// Request channel of the typed mutex table: valid/ready plus request fields.
// Depends on tmt_pkg.
`timescale 1ns / 1ps

interface tmt_req_if import tmt_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [INDEX_W-1:0]  mutex_index;
    logic [CORE_W-1:0]   core_id;
    logic [TYPE_W-1:0]   mutex_type;

    modport source (
        output valid,
        input  ready,
        output action,
        output mutex_index,
        output core_id,
        output mutex_type
    );

    modport sink (
        input  valid,
        output ready,
        input  action,
        input  mutex_index,
        input  core_id,
        input  mutex_type
    );

endinterface

// ----- rtl/tmt_rsp_if.sv -----
// Response channel of the typed mutex table: valid/ready plus status and depth.
// Depends on tmt_pkg.
`timescale 1ns / 1ps

interface tmt_rsp_if import tmt_pkg::*; ();

    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic [DEPTH_OUT_W-1:0] depth;

    modport source (
        output valid,
        input  ready,
        output status,
        output depth
    );

    modport sink (
        input  valid,
        output ready,
        input  status,
        input  depth
    );

endinterface

// ----- rtl/typed_mutex_table_unit.sv -----
// Typed mutex table: one request beat in, one response beat out, in order.
// A request is captured in an input register; from there the addressed
// entry is read, updated and written back while the response is loaded into
// an output register. One request is taken every cycle as long as the
// response side keeps up; a response is held in the output register until
// it is taken, and the input register waits behind it meanwhile.
// The rate is set by the single read-modify-write of the entry table per
// cycle, done in flip-flops so that back-to-back requests to the same mutex
// see each other's updates.
// Depends on tmt_pkg, tmt_req_if and tmt_rsp_if.
`timescale 1ns / 1ps

module typed_mutex_table_unit import tmt_pkg::*; #(
    parameter int MUTEX_COUNT = 16,
    parameter int CORE_COUNT  = 16,
    parameter int DEPTH_WIDTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    tmt_req_if.sink   req,
    tmt_rsp_if.source rsp
);

    // entries an index field can reach, and bits to address them
    localparam int ENTRY_COUNT = (MUTEX_COUNT < INDEX_REACH) ? MUTEX_COUNT : INDEX_REACH;
    localparam int IDX_W       = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
    localparam int CORE_REACH  = (CORE_COUNT < CORE_REACH_MAX) ? CORE_COUNT : CORE_REACH_MAX;
    localparam int OWNER_W     = (CORE_REACH > 1) ? $clog2(CORE_REACH) : 1;

    // entry table
    logic [TYPE_W-1:0]      type_reg  [ENTRY_COUNT];
    logic                   owned_reg [ENTRY_COUNT];
    logic [OWNER_W-1:0]     owner_reg [ENTRY_COUNT];
    logic [DEPTH_WIDTH-1:0] depth_reg [ENTRY_COUNT];

    // input register
    logic                s1_valid_reg;
    logic [ACTION_W-1:0] s1_action_reg;
    logic [INDEX_W-1:0]  s1_index_reg;
    logic [CORE_W-1:0]   s1_core_reg;
    logic [TYPE_W-1:0]   s1_type_reg;

    // output register
    logic                   out_valid_reg;
    logic [STATUS_W-1:0]    out_status_reg;
    logic [DEPTH_OUT_W-1:0] out_depth_reg;

    // handshake
    logic s1_advance;
    logic req_fire;
    logic table_we;

    // entry read and update
    logic [IDX_W-1:0]        idx;
    logic                    idx_ok;
    logic                    core_ok;
    logic [OWNER_W-1:0]      core_own;
    logic [TYPE_W-1:0]       cur_type;
    logic                    cur_owned;
    logic [OWNER_W-1:0]      cur_owner;
    logic [DEPTH_WIDTH-1:0]  cur_depth;
    logic                    mine;
    logic                    type_ok;
    logic [TYPE_W-1:0]       type_next;
    logic                    owned_next;
    logic [OWNER_W-1:0]      owner_next;
    logic [DEPTH_WIDTH-1:0]  depth_next;
    logic [STATUS_W-1:0]     status_next;
    logic [DEPTH_WIDE_W-1:0] depth_wide;
    logic [DEPTH_OUT_W-1:0]  depth_out;

    // flow control: the input stage moves when the output register is free or being taken
    assign s1_advance = !out_valid_reg || rsp.ready;
    assign req.ready  = !s1_valid_reg || s1_advance;
    assign req_fire   = req.valid && req.ready;

    // request capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_action_reg <= req.action;
            s1_index_reg  <= req.mutex_index;
            s1_core_reg   <= req.core_id;
            s1_type_reg   <= req.mutex_type;
        end
    end

    // entry read
    assign idx       = s1_index_reg[IDX_W-1:0];
    assign idx_ok    = 32'(s1_index_reg) < MUTEX_COUNT;
    assign core_ok   = 32'(s1_core_reg) < CORE_COUNT;
    assign core_own  = OWNER_W'(s1_core_reg);
    assign cur_type  = type_reg[idx];
    assign cur_owned = owned_reg[idx];
    assign cur_owner = owner_reg[idx];
    assign cur_depth = depth_reg[idx];
    assign mine      = cur_owned && (cur_owner == core_own);
    assign type_ok   = cur_type <= TYPE_DEFAULT;

    // request decode and entry update
    always_comb
    begin
        type_next   = cur_type;
        owned_next  = cur_owned;
        owner_next  = cur_owner;
        depth_next  = cur_depth;
        status_next = ST_INVALID;
        if (core_ok)
        begin
            case (s1_action_reg)
                ACT_INIT:
                begin
                    if (s1_type_reg <= TYPE_DEFAULT)
                    begin
                        type_next   = s1_type_reg;
                        owned_next  = 1'b0;
                        owner_next  = '0;
                        depth_next  = '0;
                        status_next = ST_OK;
                    end
                end
                ACT_LOCK, ACT_TRYLOCK:
                begin
                    if (!type_ok)
                    begin
                        status_next = ST_INVALID;
                    end
                    else if (mine && cur_type == TYPE_ERRORCHECK)
                    begin
                        status_next = ST_DEADLOCK;
                    end
                    else if (mine && (cur_type == TYPE_RECURSIVE ||
                                      cur_type == TYPE_DEFAULT))
                    begin
                        // recursive relock, saturating count
                        if (cur_depth == {DEPTH_WIDTH{1'b1}})
                        begin
                            status_next = ST_AGAIN;
                        end
                        else
                        begin
                            depth_next  = cur_depth + DEPTH_WIDTH'(1);
                            status_next = ST_OK;
                        end
                    end
                    else if (cur_owned)
                    begin
                        status_next = (s1_action_reg == ACT_LOCK) ? ST_WAIT : ST_BUSY;
                    end
                    else
                    begin
                        owned_next  = 1'b1;
                        owner_next  = core_own;
                        status_next = ST_OK;
                    end
                end
                ACT_UNLOCK:
                begin
                    if (!mine)
                    begin
                        status_next = ST_NOT_OWNER;
                    end
                    else if (cur_depth != '0)
                    begin
                        depth_next  = cur_depth - DEPTH_WIDTH'(1);
                        status_next = ST_OK;
                    end
                    else
                    begin
                        owned_next  = 1'b0;
                        owner_next  = '0;
                        status_next = ST_OK;
                    end
                end
                default:
                begin
                    status_next = ST_INVALID;
                end
            endcase
        end
    end

    // reported depth, zero for an index outside the table
    assign depth_wide = DEPTH_WIDE_W'(depth_next);
    assign depth_out  = idx_ok ? depth_wide[DEPTH_OUT_W-1:0] : '0;

    assign table_we = s1_valid_reg && s1_advance && idx_ok && core_ok;

    // entry write back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRY_COUNT; i++)
            begin
                type_reg[i]  <= TYPE_NONE;
                owned_reg[i] <= 1'b0;
                owner_reg[i] <= '0;
                depth_reg[i] <= '0;
            end
        end
        else if (table_we)
        begin
            type_reg[idx]  <= type_next;
            owned_reg[idx] <= owned_next;
            owner_reg[idx] <= owner_next;
            depth_reg[idx] <= depth_next;
        end
    end

    // response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_valid_reg)
        begin
            out_status_reg <= idx_ok ? status_next : ST_INVALID;
            out_depth_reg  <= depth_out;
        end
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.status = out_status_reg;
    assign rsp.depth  = out_depth_reg;

endmodule
